>>> hw/rtl/fsrp_pkg.sv
// ----------------------------------------------------------------------------
// fsrp_pkg
// Shared types and constants for the fixed-slot record page.
// ----------------------------------------------------------------------------
package fsrp_pkg;

  localparam int MAX_SLOTS_DEF   = 256;
  localparam int RECORD_BITS_DEF = 64;

  localparam int CMD_W = 3;
  localparam int IDX_W = 9;
  localparam int OTH_W = 8;
  localparam int REC_W = 64;
  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] CAPACITY_RST = 9'd256;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWAP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DROP    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] slot_index;
    logic [OTH_W-1:0] other_index;
    logic             has_record;
    logic [REC_W-1:0] record_in;
  } cmd_item_t;

  typedef struct packed {
    logic             ok;
    logic             record_present;
    logic [REC_W-1:0] record_out;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] tombstone_total;
    logic [CNT_W-1:0] dropped_count;
  } result_t;

endpackage

>>> hw/rtl/fsrp_slot_ram.sv
// ----------------------------------------------------------------------------
// fsrp_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsrp_slot_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/fixed_slot_record_page.sv
// ----------------------------------------------------------------------------
// fixed_slot_record_page
// Page of fixed-size record slots with tombstones, kept in one slot RAM and
// edited by a small sequencer one slot per cycle.
//
//   channel   ports                     handshake
//   command   item                      start, taken when busy is low
//   result    result                    done, one cycle, cannot be stalled
//   config    cfg_wdata                 cfg_write, taken at once
//
// After decode, insert shifts slots up from the index and writes the new one;
// discard shifts the tail down; drop scans trailing tombstones; swap, update
// and get read before they write or answer; clear and refused commands end in
// decode. The single RAM port pair sets the one-slot-per-cycle move rate.
// busy is high from acceptance until the result beat; the result beat and the
// next acceptance may share a cycle.
// Reset clears the used and tombstone counts and sets capacity to 256; slot
// contents are not cleared, slots beyond the used count are never read.
// ----------------------------------------------------------------------------
module fixed_slot_record_page #(
  parameter int MAX_SLOTS   = fsrp_pkg::MAX_SLOTS_DEF,
  parameter int RECORD_BITS = fsrp_pkg::RECORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  fsrp_pkg::cmd_item_t          item,
  output logic                         done,
  output fsrp_pkg::result_t            result,
  input  logic                         cfg_write,
  input  logic [fsrp_pkg::CNT_W-1:0]   cfg_wdata
);
  import fsrp_pkg::*;

  localparam int AW  = $clog2(MAX_SLOTS);
  localparam int CW  = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;
  localparam int EW  = RECORD_BITS + 1;
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MOVE, S_PUT, S_UPD, S_DISC,
    S_SWAP_B, S_SWAP_WA, S_SWAP_WB, S_GET, S_DROP
  } state_t;

  state_t            state, state_next;
  cmd_item_t         cmd_q, cmd_q_next;
  logic [CNT_W-1:0]  capacity;
  logic [CW-1:0]     used_cnt, used_cnt_next;
  logic [CW-1:0]     tomb_cnt, tomb_cnt_next;
  logic [CW-1:0]     move_left, move_left_next;
  logic [CW-1:0]     scan_left, scan_left_next;
  logic [CW-1:0]     dropped, dropped_next;
  logic [AW-1:0]     src, src_next;
  logic [AW-1:0]     rd_dst, rd_dst_next;
  logic              rd_pend, rd_pend_next;
  logic [EW-1:0]     hold, hold_next;
  logic              done_next;
  result_t           result_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  logic [CW-1:0]          ix, ox, cap_ext, cap_eff;
  logic [RECORD_BITS-1:0] rec_in;
  logic                   fin, fin_ok, fin_present;
  logic [RECORD_BITS-1:0] fin_rec;
  logic                   rd_valid;

  fsrp_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state != S_IDLE);
  assign ix       = CW'(cmd_q.slot_index);
  assign ox       = CW'(cmd_q.other_index);
  assign cap_ext  = CW'(capacity);
  assign cap_eff  = (cap_ext > MAX_C) ? MAX_C : cap_ext;
  assign rec_in   = RECORD_BITS'(cmd_q.record_in);
  assign rd_valid = ram_rdata[EW-1];

  always_comb begin
    state_next     = state;
    cmd_q_next     = cmd_q;
    used_cnt_next  = used_cnt;
    tomb_cnt_next  = tomb_cnt;
    move_left_next = move_left;
    scan_left_next = scan_left;
    dropped_next   = dropped;
    src_next       = src;
    rd_dst_next    = rd_dst;
    rd_pend_next   = rd_pend;
    hold_next      = hold;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    fin            = 1'b0;
    fin_ok         = 1'b0;
    fin_present    = 1'b0;
    fin_rec        = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next = item;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        dropped_next = '0;
        rd_pend_next = 1'b0;
        case (cmd_q.cmd)
          CMD_INSERT: begin
            if (ix <= used_cnt && used_cnt < cap_eff) begin
              move_left_next = used_cnt - ix;
              src_next       = AW'(used_cnt - ONE_C);
              state_next     = S_MOVE;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_UPDATE: begin
            if (ix < used_cnt) begin
              ram_raddr  = AW'(ix);
              state_next = S_UPD;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_DISCARD: begin
            if (ix < used_cnt) begin
              ram_raddr      = AW'(ix);
              move_left_next = used_cnt - ix - ONE_C;
              src_next       = AW'(ix + ONE_C);
              state_next     = S_DISC;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_SWAP: begin
            if (ix < used_cnt && ox < used_cnt) begin
              ram_raddr  = AW'(ix);
              state_next = S_SWAP_B;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_GET: begin
            if (ix < used_cnt) begin
              ram_raddr  = AW'(ix);
              state_next = S_GET;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_DROP: begin
            scan_left_next = used_cnt;
            state_next     = S_DROP;
          end
          CMD_CLEAR: begin
            used_cnt_next = '0;
            tomb_cnt_next = '0;
            fin           = 1'b1;
            fin_ok        = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_MOVE: begin
        // read ahead one slot, write the previous read to its new place
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = rd_dst;
          ram_wdata = ram_rdata;
        end
        if (move_left != '0) begin
          ram_raddr      = src;
          rd_pend_next   = 1'b1;
          move_left_next = move_left - ONE_C;
          if (cmd_q.cmd == CMD_INSERT) begin
            rd_dst_next = src + 1'b1;
            src_next    = src - 1'b1;
          end else begin
            rd_dst_next = src - 1'b1;
            src_next    = src + 1'b1;
          end
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            if (cmd_q.cmd == CMD_INSERT) begin
              state_next = S_PUT;
            end else begin
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
          end
        end
      end
      S_PUT: begin
        ram_we        = 1'b1;
        ram_waddr     = AW'(ix);
        ram_wdata     = {cmd_q.has_record, cmd_q.has_record ? rec_in : '0};
        used_cnt_next = used_cnt + ONE_C;
        if (!cmd_q.has_record) begin
          tomb_cnt_next = tomb_cnt + ONE_C;
        end
        fin    = 1'b1;
        fin_ok = 1'b1;
      end
      S_UPD: begin
        if (rd_valid && !cmd_q.has_record) begin
          tomb_cnt_next = tomb_cnt + ONE_C;
        end else if (!rd_valid && cmd_q.has_record) begin
          tomb_cnt_next = tomb_cnt - ONE_C;
        end
        ram_we    = 1'b1;
        ram_waddr = AW'(ix);
        ram_wdata = {cmd_q.has_record,
                     cmd_q.has_record ? rec_in : ram_rdata[RECORD_BITS-1:0]};
        fin       = 1'b1;
        fin_ok    = 1'b1;
      end
      S_DISC: begin
        used_cnt_next = used_cnt - ONE_C;
        if (!rd_valid) begin
          tomb_cnt_next = tomb_cnt - ONE_C;
        end
        state_next = S_MOVE;
      end
      S_SWAP_B: begin
        hold_next  = ram_rdata;
        ram_raddr  = AW'(ox);
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(ix);
        ram_wdata  = ram_rdata;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ox);
        ram_wdata = hold;
        fin       = 1'b1;
        fin_ok    = 1'b1;
      end
      S_GET: begin
        fin         = 1'b1;
        fin_ok      = 1'b1;
        fin_present = rd_valid;
        fin_rec     = rd_valid ? ram_rdata[RECORD_BITS-1:0] : '0;
      end
      S_DROP: begin
        // last slot is checked while the one below it is read
        if (rd_pend && !rd_valid) begin
          used_cnt_next = used_cnt - ONE_C;
          if (tomb_cnt != '0) begin
            tomb_cnt_next = tomb_cnt - ONE_C;
          end
          dropped_next = dropped + ONE_C;
        end
        if (rd_pend && rd_valid) begin
          rd_pend_next = 1'b0;
          fin          = 1'b1;
          fin_ok       = 1'b1;
        end else if (scan_left != '0) begin
          ram_raddr      = AW'(scan_left - ONE_C);
          scan_left_next = scan_left - ONE_C;
          rd_pend_next   = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          if (!rd_pend) begin
            fin    = 1'b1;
            fin_ok = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
    done_next                      = fin;
    result_next.ok                 = fin_ok;
    result_next.record_present     = fin_present;
    result_next.record_out         = REC_W'(fin_rec);
    result_next.used_count         = CNT_W'(used_cnt_next);
    result_next.tombstone_total    = CNT_W'(tomb_cnt_next);
    result_next.dropped_count      = CNT_W'(dropped_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used_cnt <= '0;
      tomb_cnt <= '0;
      capacity <= CAPACITY_RST;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      used_cnt <= used_cnt_next;
      tomb_cnt <= tomb_cnt_next;
      rd_pend  <= rd_pend_next;
      done     <= done_next;
      if (cfg_write) begin
        capacity <= cfg_wdata;
      end
    end
    cmd_q     <= cmd_q_next;
    move_left <= move_left_next;
    scan_left <= scan_left_next;
    dropped   <= dropped_next;
    src       <= src_next;
    rd_dst    <= rd_dst_next;
    hold      <= hold_next;
    if (fin) begin
      result <= result_next;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in flight");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not start");

  a_tomb_le_used: assert property (@(posedge clk) disable iff (rst)
    tomb_cnt <= used_cnt)
    else $error("tombstone count above used count");

  a_used_le_max: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= MAX_C)
    else $error("used count above page size");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("slot write while idle");

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-slot record page. A scoreboard mirrors the
// slot array and both counts, predicts the result beat of every accepted
// command and checks each beat in order. A short directed pass hits empty-page
// and out-of-range cases, then random phases at several capacities (zero, one,
// full page, oversized, below the fill level) run mostly in-range traffic with
// some noise.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fsrp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int PAGE_SLOTS    = MAX_SLOTS_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;

  class page_scoreboard;
    bit               slot_full [PAGE_SLOTS];
    logic [REC_W-1:0] slot_word [PAGE_SLOTS];
    int unsigned      used;
    int unsigned      tombs;
    int unsigned      capacity;
    result_t          awaited [$];
    int unsigned      mismatches;
    int unsigned      accepted;
    int unsigned      checked;
    int unsigned      peak_used;
    int unsigned      refused_inserts;
    int unsigned      dropped_total;

    function new();
      used            = 0;
      tombs           = 0;
      capacity        = CAPACITY_RST;
      mismatches      = 0;
      accepted        = 0;
      checked         = 0;
      peak_used       = 0;
      refused_inserts = 0;
      dropped_total   = 0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] v);
      capacity = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_command(cmd_item_t c);
      result_t          r;
      int unsigned      lim;
      int unsigned      k;
      int unsigned      idx;
      int unsigned      oth;
      int unsigned      dropped;
      bit               keep_v;
      logic [REC_W-1:0] keep_w;
      r       = '0;
      dropped = 0;
      idx     = c.slot_index;
      oth     = c.other_index;
      lim     = (capacity > PAGE_SLOTS) ? PAGE_SLOTS : capacity;
      accepted++;
      case (c.cmd)
        CMD_INSERT: begin
          if (idx <= used && used < lim) begin
            for (k = used; k > idx; k--) begin
              slot_full[k] = slot_full[k-1];
              slot_word[k] = slot_word[k-1];
            end
            slot_full[idx] = c.has_record;
            slot_word[idx] = c.has_record ? c.record_in : '0;
            used++;
            if (!c.has_record) tombs++;
            r.ok = 1'b1;
          end else begin
            refused_inserts++;
          end
        end
        CMD_UPDATE: begin
          if (idx < used) begin
            if (slot_full[idx] && !c.has_record) tombs++;
            else if (!slot_full[idx] && c.has_record) tombs--;
            slot_full[idx] = c.has_record;
            if (c.has_record) slot_word[idx] = c.record_in;
            r.ok = 1'b1;
          end
        end
        CMD_DISCARD: begin
          if (idx < used) begin
            keep_v = slot_full[idx];
            for (k = idx + 1; k < used; k++) begin
              slot_full[k-1] = slot_full[k];
              slot_word[k-1] = slot_word[k];
            end
            used--;
            if (!keep_v) tombs--;
            r.ok = 1'b1;
          end
        end
        CMD_SWAP: begin
          if (idx < used && oth < used) begin
            keep_v         = slot_full[idx];
            keep_w         = slot_word[idx];
            slot_full[idx] = slot_full[oth];
            slot_word[idx] = slot_word[oth];
            slot_full[oth] = keep_v;
            slot_word[oth] = keep_w;
            r.ok = 1'b1;
          end
        end
        CMD_GET: begin
          if (idx < used) begin
            r.ok = 1'b1;
            if (slot_full[idx]) begin
              r.record_present = 1'b1;
              r.record_out     = slot_word[idx];
            end
          end
        end
        CMD_DROP: begin
          while (used > 0 && !slot_full[used-1]) begin
            used--;
            if (tombs > 0) tombs--;
            dropped++;
          end
          dropped_total += dropped;
          r.ok = 1'b1;
        end
        CMD_CLEAR: begin
          used  = 0;
          tombs = 0;
          r.ok  = 1'b1;
        end
        default: begin
        end
      endcase
      if (used > peak_used) peak_used = used;
      r.used_count      = used[CNT_W-1:0];
      r.tombstone_total = tombs[CNT_W-1:0];
      r.dropped_count   = dropped[CNT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: ok=%0b used=%0d", got.ok, got.used_count);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.ok !== want.ok || got.record_present !== want.record_present ||
          got.record_out !== want.record_out || got.used_count !== want.used_count ||
          got.tombstone_total !== want.tombstone_total ||
          got.dropped_count !== want.dropped_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d: want ok=%0b pres=%0b rec=%h used=%0d tomb=%0d drop=%0d",
                   checked, want.ok, want.record_present, want.record_out,
                   want.used_count, want.tombstone_total, want.dropped_count);
          $display("                      got  ok=%0b pres=%0b rec=%h used=%0d tomb=%0d drop=%0d",
                   got.ok, got.record_present, got.record_out,
                   got.used_count, got.tombstone_total, got.dropped_count);
        end
      end
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  cmd_item_t        item      = '0;
  logic             done;
  result_t          result;
  logic             cfg_write = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  page_scoreboard sb;
  int unsigned    quiet_cycles = 0;
  int unsigned    cap_writes   = 0;

  fixed_slot_record_page dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [REC_W-1:0] random_word();
    case ($urandom_range(0, 19))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly below bound, sometimes anywhere in the 9-bit field
  function automatic logic [IDX_W-1:0] slot_pick(int unsigned bound);
    if (bound == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 511));
    return IDX_W'($urandom_range(0, bound - 1));
  endfunction

  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                                         logic [OTH_W-1:0] oth, logic has,
                                         logic [REC_W-1:0] rec);
    cmd_item_t c;
    c.cmd         = op;
    c.slot_index  = idx;
    c.other_index = oth;
    c.has_record  = has;
    c.record_in   = rec;
    return c;
  endfunction

  function automatic cmd_item_t random_command(int unsigned used);
    cmd_item_t   c;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    c.slot_index  = slot_pick(used);
    c.other_index = (used > 0 && $urandom_range(0, 9) != 0)
                    ? OTH_W'($urandom_range(0, used - 1))
                    : OTH_W'($urandom_range(0, 255));
    c.has_record  = ($urandom_range(0, 3) != 0);
    c.record_in   = random_word();
    if (roll < 38) begin
      c.cmd        = CMD_INSERT;
      c.slot_index = slot_pick(used + 1);
    end else if (roll < 50) c.cmd = CMD_UPDATE;
    else if (roll < 60) c.cmd = CMD_DISCARD;
    else if (roll < 68) c.cmd = CMD_SWAP;
    else if (roll < 84) c.cmd = CMD_GET;
    else if (roll < 91) c.cmd = CMD_DROP;
    else if (roll < 94) c.cmd = CMD_CLEAR;
    else if (roll < 96) c.cmd = CMD_UNUSED;
    else begin
      c.cmd        = CMD_W'($urandom_range(0, 7));
      c.slot_index = IDX_W'($urandom_range(0, 511));
    end
    return c;
  endfunction

  // start is left high after acceptance so back-to-back beats need no toggle
  task automatic send_command(input cmd_item_t c, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item  <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(c);
  endtask

  task automatic drain_page();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    drain_page();
    cfg_wdata <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  task automatic run_directed();
    send_command(make_cmd(CMD_GET, '0, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_INSERT, 9'd1, '0, 1'b1, '1), 0);
    send_command(make_cmd(CMD_INSERT, '0, '0, 1'b1, '1), 0);
    send_command(make_cmd(CMD_INSERT, 9'd1, '0, 1'b0, 64'hdead_beef_0bad_f00d), 0);
    send_command(make_cmd(CMD_INSERT, '0, 8'd255, 1'b1, '0), 0);
    send_command(make_cmd(CMD_GET, '0, '0, 1'b1, '0), 0);
    send_command(make_cmd(CMD_GET, 9'd1, '0, 1'b1, '0), 0);
    send_command(make_cmd(CMD_GET, 9'd2, '0, 1'b1, '0), 0);
    send_command(make_cmd(CMD_GET, 9'd3, '0, 1'b1, '0), 0);
    send_command(make_cmd(CMD_UPDATE, 9'd2, '0, 1'b1, 64'h0123_4567_89ab_cdef), 0);
    send_command(make_cmd(CMD_UPDATE, '0, '0, 1'b0, '1), 0);
    send_command(make_cmd(CMD_SWAP, '0, 8'd2, 1'b0, '0), 0);
    send_command(make_cmd(CMD_SWAP, 9'd1, 8'd1, 1'b0, '0), 0);
    send_command(make_cmd(CMD_SWAP, '0, 8'd255, 1'b0, '0), 0);
    send_command(make_cmd(CMD_DISCARD, 9'd3, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_DISCARD, '0, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_UNUSED, '0, '0, 1'b1, '1), 0);
    send_command(make_cmd(CMD_INSERT, 9'd511, '0, 1'b1, '1), 0);
    send_command(make_cmd(CMD_INSERT, 9'd2, '0, 1'b0, '1), 0);
    send_command(make_cmd(CMD_INSERT, 9'd3, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_DROP, '0, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_UPDATE, 9'd256, '0, 1'b1, '1), 0);
    send_command(make_cmd(CMD_CLEAR, '0, '0, 1'b0, '0), 0);
    send_command(make_cmd(CMD_DROP, '0, '0, 1'b0, '0), 0);
  endtask

  task automatic run_random();
    cmd_item_t        c;
    logic [CNT_W-1:0] cap;
    int unsigned      ph;
    int unsigned      i;
    int unsigned      n;
    int unsigned      gap;
    bit               quiet;
    for (ph = 0; ph < 17; ph++) begin
      case (ph)
        0:       cap = 9'd511;
        1:       cap = 9'd256;
        2:       cap = 9'd3;
        3:       cap = 9'd0;
        4:       cap = 9'd1;
        default: begin
          case ($urandom_range(0, 7))
            0:       cap = CNT_W'($urandom_range(1, 511));
            1:       cap = 9'd256;
            default: cap = CNT_W'($urandom_range(2, 40));
          endcase
        end
      endcase
      write_capacity(cap);
      quiet = (ph == 1) || (ph >= 14);
      n     = (ph == 0) ? 300 : 103;
      for (i = 0; i < n; i++) begin
        // first phase fills the page with appends, then runs into page full
        if (ph == 0 && $urandom_range(0, 99) < 85)
          c = make_cmd(CMD_INSERT, IDX_W'(sb.used), OTH_W'($urandom_range(0, 255)),
                       $urandom_range(0, 3) != 0, random_word());
        else
          c = random_command(sb.used);
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        send_command(c, gap);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    drain_page();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d commands, %0d result beats, %0d capacity writes",
             sb.accepted, sb.checked, cap_writes);
    $display("peak fill %0d slots, %0d inserts refused, %0d tombstones dropped, %0d mismatches",
             sb.peak_used, sb.refused_inserts, sb.dropped_total, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fsrp_pkg.sv
hw/rtl/fsrp_slot_ram.sv
hw/rtl/fixed_slot_record_page.sv
bench/testbench.sv
